### sv/sgns_pkg.sv
`default_nettype none
package sgns_pkg;
  // Register indexes of the configuration port.
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;
  // Direction codes.
  localparam logic [1:0] DIR_HORZ = 2'd0;
  localparam logic [1:0] DIR_VERT = 2'd1;
  localparam logic [1:0] DIR_NEG45 = 2'd2;
  localparam logic [1:0] DIR_POS45 = 2'd3;
  // tan(22.5) and tan(67.5) in unsigned Q32, truncated.
  localparam logic [34:0] TAN_22_5_Q32 = 35'h06A09E667;
  localparam logic [34:0] TAN_67_5_Q32 = 35'h26A09E667;

  typedef struct packed {
    logic [7:0] pixel;
    logic       start_frame;
  } in_req_t;

  typedef struct packed {
    logic [7:0] edge_magnitude;
    logic [1:0] direction;
    logic       last_of_frame;
  } out_req_t;
endpackage
`default_nettype wire

### sv/sgns_if.sv
`default_nettype none
interface sgns_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/sgns_ram.sv
`default_nettype none
module sgns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/sobel_gradient_nonmax_suppress_unit.sv
// Sobel gradient with non-maximum suppression over a raster pixel stream.
// Input channel in_ch: one request per pixel (pixel, start_frame); start_frame
// restarts row and column counting. Configuration channel cfg_ch: index 0 is
// the image width (saturated into 5..MAX_WIDTH), index 1 the height (at least
// 5); a write is taken only while no pixel is in progress.
// Output channel out_ch: one request per interior position (x,y) with
// 2<=x<=W-3, 2<=y<=H-3, carrying the suppressed magnitude, the direction and
// last_of_frame, produced when pixel (x+2,y+2) is processed.
// Each pixel passes in order through the accepting cycle, a read of both
// line-buffer memories, the Sobel sums and squares, the square root (four
// result bits per cycle) with the direction, and suppression and write-back.
// A new pixel is taken only once the previous one has been written back.
// The result sits in an output register; if it is still waiting when the
// next result is due, that pixel holds in its write-back cycle and the
// input stalls until the old result has been taken.
// After reset both line-buffer memories are cleared to zero, one entry per
// cycle over all MAX_WIDTH entries, during which no request is taken.
`default_nettype none
module sobel_gradient_nonmax_suppress_unit
  import sgns_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  sgns_if.sink   in_ch,
  sgns_if.source out_ch,
  sgns_if.sink   cfg_ch
);
  localparam int AW = $clog2(MAX_WIDTH);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_SOBEL, S_ROOT, S_WRITE} state_t;

  state_t      state_r;
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [AW:0] col_r;
  logic [15:0] row_r;
  logic [7:0]  pw_r [9];
  logic [9:0]  gw_r [9];
  logic [7:0]  pix_r;
  logic [AW:0] ccol_r;
  logic [15:0] crow_r;
  logic        ov_r;
  out_req_t    out_r;
  logic signed [11:0] gx_r, gy_r;
  logic [21:0] rem_r;
  logic [11:0] root_r;
  logic [2:0]  it_r;
  logic [1:0]  dir_r;
  logic [AW-1:0] clr_r;

  // Effective geometry.
  logic [AW:0] eff_w;
  logic [15:0] eff_h;
  always_comb begin
    if (width_r < 11'd5) eff_w = (AW+1)'(5);
    else if ({21'd0, width_r} > 32'(MAX_WIDTH)) eff_w = (AW+1)'(MAX_WIDTH);
    else eff_w = (AW+1)'(width_r);
    eff_h = (height_r < 16'd5) ? 16'd5 : height_r;
  end

  // Line buffer memories: pixel rows packed as {older, newer}, same for gradients.
  // While clearing, both memories take zeros at the clear address.
  logic [15:0] prd;
  logic [19:0] grd;
  logic        we_p, we_g;
  logic        clr_on;
  logic [AW-1:0] gaddr;
  assign clr_on = state_r == S_CLEAR;
  assign gaddr = AW'(ccol_r - 1'b1);
  sgns_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_pix (
    .clk(clk), .we(we_p || clr_on), .waddr(clr_on ? clr_r : ccol_r[AW-1:0]),
    .wdata(clr_on ? 16'd0 : {prd[7:0], pix_r}),
    .raddr(ccol_r[AW-1:0]), .rdata(prd));
  logic [9:0] g_new;
  sgns_ram #(.WIDTH(20), .DEPTH(MAX_WIDTH)) u_grd (
    .clk(clk), .we(we_g || clr_on), .waddr(clr_on ? clr_r : gaddr),
    .wdata(clr_on ? 20'd0 : {grd[9:0], g_new}),
    .raddr(gaddr), .rdata(grd));

  // Sobel on the shifted window.
  logic [7:0] p [9];
  always_comb begin
    p[0] = pw_r[1]; p[1] = pw_r[2]; p[2] = prd[15:8];
    p[3] = pw_r[4]; p[4] = pw_r[5]; p[5] = prd[7:0];
    p[6] = pw_r[7]; p[7] = pw_r[8]; p[8] = pix_r;
  end
  logic signed [11:0] gx_c, gy_c;
  assign gx_c = 12'(signed'({4'd0, p[2]})) - 12'(signed'({4'd0, p[0]}))
              + 12'(signed'({3'd0, p[5], 1'b0})) - 12'(signed'({3'd0, p[3], 1'b0}))
              + 12'(signed'({4'd0, p[8]})) - 12'(signed'({4'd0, p[6]}));
  assign gy_c = 12'(signed'({4'd0, p[0]})) + 12'(signed'({3'd0, p[1], 1'b0}))
              + 12'(signed'({4'd0, p[2]})) - 12'(signed'({4'd0, p[6]}))
              - 12'(signed'({3'd0, p[7], 1'b0})) - 12'(signed'({4'd0, p[8]}));

  logic [10:0] ax, ay;
  assign ax = gx_r[11] ? 11'(-gx_r) : 11'(gx_r);
  assign ay = gy_r[11] ? 11'(-gy_r) : 11'(gy_r);

  // Direction classification by exact Q32 compare.
  logic [45:0] lhs, t22, t67;
  logic [1:0]  dir_c;
  always_comb begin
    lhs = {3'd0, ay, 32'd0};
    t22 = 46'(TAN_22_5_Q32) * 46'(ax);
    t67 = 46'(TAN_67_5_Q32) * 46'(ax);
    if (ax == 11'd0) dir_c = DIR_VERT;
    else if (lhs < t22) dir_c = DIR_HORZ;
    else if (lhs > t67) dir_c = DIR_VERT;
    else dir_c = (gx_r[11] != gy_r[11]) ? DIR_NEG45 : DIR_POS45;
  end

  // Four root bits per cycle of the restoring square root; eleven bits in all,
  // most significant first.
  logic [21:0] rem_nxt;
  logic [11:0] root_nxt;
  always_comb begin
    logic [21:0] tr;
    int          step;
    rem_nxt = rem_r;
    root_nxt = root_r;
    tr = '0;
    for (int k = 0; k < 4; k++) begin
      step = 4 * int'(it_r) + k;
      if (step < 11) begin
        tr = 22'({root_nxt, 2'b01}) << (2 * (10 - step));
        if (rem_nxt >= tr) begin
          rem_nxt = rem_nxt - tr;
          root_nxt = {root_nxt[10:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[10:0], 1'b0};
        end
      end
    end
  end
  assign g_new = {dir_r, (root_r > 12'd255) ? 8'd255 : root_r[7:0]};

  // Suppression on the shifted gradient window.
  logic [9:0] m [9];
  always_comb begin
    m[0] = gw_r[1]; m[1] = gw_r[2]; m[2] = grd[19:10];
    m[3] = gw_r[4]; m[4] = gw_r[5]; m[5] = grd[9:0];
    m[6] = gw_r[7]; m[7] = gw_r[8]; m[8] = g_new;
  end
  logic [7:0] n1, n2, mag_o;
  always_comb begin
    unique case (m[4][9:8])
      DIR_HORZ: begin n1 = m[5][7:0]; n2 = m[3][7:0]; end
      DIR_VERT: begin n1 = m[7][7:0]; n2 = m[1][7:0]; end
      DIR_NEG45: begin n1 = m[2][7:0]; n2 = m[6][7:0]; end
      default: begin n1 = m[8][7:0]; n2 = m[0][7:0]; end
    endcase
    mag_o = (m[4][7:0] < n1 || m[4][7:0] < n2) ? 8'd0 : m[4][7:0];
  end

  // Write-back goes ahead once the output register is free or being emptied.
  logic grad_pt, out_pt, wr_go, emit;
  assign grad_pt = ccol_r >= (AW+1)'(2) && crow_r >= 16'd2;
  assign out_pt  = ccol_r >= (AW+1)'(4) && crow_r >= 16'd4;
  assign wr_go = state_r == S_WRITE && !(ov_r && !out_ch.ready);
  assign emit  = wr_go && grad_pt && out_pt;
  assign we_p = state_r == S_SOBEL;
  assign we_g = wr_go && grad_pt;

  in_req_t in_p;
  assign in_p = in_req_t'(in_ch.payload);
  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = state_r == S_IDLE;
  assign out_ch.valid = ov_r;
  assign out_ch.payload = out_r;

  function automatic logic [21:0] ax_sq(input logic signed [11:0] v);
    logic [10:0] a;
    a = v[11] ? 11'(-v) : 11'(v);
    return 22'(a) * 22'(a);
  endfunction

  // Sequencer, window and counter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      width_r <= 11'd640;
      height_r <= 16'd480;
      col_r <= '0;
      row_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(MAX_WIDTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_ch.valid) begin
            if (cfg_ch.payload[16] == REG_WIDTH) width_r <= cfg_ch.payload[10:0];
            else height_r <= cfg_ch.payload[15:0];
          end
          if (in_ch.valid) begin
            pix_r <= in_p.pixel;
            ccol_r <= in_p.start_frame ? '0 : col_r;
            crow_r <= in_p.start_frame ? '0 : row_r;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_SOBEL;
        S_SOBEL: begin
          for (int k = 0; k < 9; k++) pw_r[k] <= p[k];
          gx_r <= gx_c;
          gy_r <= gy_c;
          rem_r <= 22'(ax_sq(gx_c)) + 22'(ax_sq(gy_c));
          root_r <= '0;
          it_r <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          rem_r <= rem_nxt;
          root_r <= root_nxt;
          it_r <= it_r + 3'd1;
          dir_r <= dir_c;
          if (it_r == 3'd2) state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (wr_go) begin
            if (grad_pt) for (int k = 0; k < 9; k++) gw_r[k] <= m[k];
            if (emit) begin
              out_r <= '{mag_o, m[4][9:8],
                         ccol_r == eff_w - 1'b1 && crow_r == eff_h - 16'd1};
            end
            if (ccol_r + 1'b1 >= eff_w) begin
              col_r <= '0;
              row_r <= (crow_r + 16'd1 >= eff_h) ? 16'd0 : crow_r + 16'd1;
            end else begin
              col_r <= ccol_r + 1'b1;
              row_r <= crow_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result is never overwritten before it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(out_r)) else $error("result lost");
  // Pixels are only taken while idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("pixel taken while busy");
  // Gradient row written only at interior positions.
  assert property (@(posedge clk) disable iff (!rst_n)
    we_g |-> ccol_r >= (AW+1)'(2)) else $error("bad gradient write");
endmodule
`default_nettype wire
